// ===== rtl/lif_pkg.sv =====
// shared types, constants and arithmetic helpers for the lif neuron rk4 update core
// no dependencies; used by lif_slope_unit and lif_neuron_rk4_update_core
`timescale 1ns / 1ps

package lif_pkg;

   localparam int NEURON_COUNT  = 1024;
   localparam int FRACTION_BITS = 16;
   localparam int IDX_W         = 10;

   // register reset values
   localparam logic [30:0]        LEAK_RESET  = 31'd294912;
   localparam logic signed [31:0] REST_RESET  = -32'sd4587520;
   localparam logic [30:0]        INVC_RESET  = 31'd655;
   localparam logic signed [31:0] ICUR_RESET  = 32'sd32768000;
   localparam logic [30:0]        STEP_RESET  = 31'd655;
   localparam logic signed [31:0] RLVL_RESET  = 32'sd720896;
   localparam logic signed [31:0] THRES_RESET = 32'sd1179648;

   // offset that makes the halved rk4 sum non-negative, a multiple of three
   // biased value stays below 3 * 2^32, inside 34 bits
   localparam logic signed [35:0] DIV_OFFSET = 36'sd6442450944;
   localparam logic signed [33:0] DIV_BIAS   = 34'sd2147483648;

   typedef enum logic [2:0] {
      REG_LEAK  = 3'd0,
      REG_REST  = 3'd1,
      REG_INVC  = 3'd2,
      REG_ICUR  = 3'd3,
      REG_STEP  = 3'd4,
      REG_RLVL  = 3'd5,
      REG_THRES = 3'd6
   } csr_index_type;

   typedef enum logic {
      FUNC_LOAD = 1'b0,
      FUNC_STEP = 1'b1
   } func_type;

   typedef struct packed {
      logic [30:0]        gl;
      logic signed [31:0] rest;
      logic [30:0]        invc;
      logic signed [31:0] icur;
      logic [30:0]        h;
      logic signed [31:0] reset_level;
      logic signed [31:0] threshold;
   } cfg_type;

   // per-word sideband carried along the pipeline
   typedef struct packed {
      func_type           func;
      logic [IDX_W-1:0]   idx;
      logic               in_range;
      logic signed [31:0] v;
      logic signed [31:0] k1;
      logic signed [31:0] k2;
      logic signed [31:0] k3;
   } side_type;

   function automatic logic signed [31:0] sat32(input logic signed [65:0] x);
      if (x > 66'sd2147483647) begin
         return 32'sh7fffffff;
      end else if (x < -66'sd2147483648) begin
         return 32'sh80000000;
      end
      return x[31:0];
   endfunction

   // floor(x / 3) for x below 2^19: reciprocal multiply, then one correction
   function automatic logic [18:0] div3(input logic [18:0] x);
      logic [38:0] prod;
      logic [18:0] q;
      logic [20:0] r;
      prod = 39'(x) * 39'd349525;
      q    = prod[38:20];
      r    = 21'(x) - 21'(q) * 21'd3;
      if (r >= 21'd3) begin
         q = q + 19'd1;
      end
      return q;
   endfunction

endpackage

// ===== rtl/lif_slope_unit.sv =====
// one rk4 slope evaluation k = h * (i - gl*(x - rest)) / c, four register stages
// depends on lif_pkg
`timescale 1ns / 1ps

module lif_slope_unit (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         en,
   input  lif_pkg::cfg_type             cfg,
   input  logic                         in_valid,
   input  logic signed [31:0]           x_in,
   input  lif_pkg::side_type            side_in,
   input  logic [lif_pkg::IDX_W-1:0]    probe_idx,
   output logic                         out_valid,
   output logic signed [31:0]           k_out,
   output lif_pkg::side_type            side_out,
   output logic                         hit
);

   logic                valid_ff [4];
   lif_pkg::side_type   side_ff  [4];
   logic signed [63:0]  p1_ff, p2_ff, p3_ff;
   logic signed [31:0]  k_ff;
   logic signed [63:0]  p1_in, p2_in, p3_in;
   logic signed [31:0]  diff, leak, num, deriv, k_in;

   always_comb begin
      diff  = lif_pkg::sat32(66'(x_in) - 66'(cfg.rest));
      p1_in = $signed({1'b0, cfg.gl}) * diff;
      leak  = lif_pkg::sat32(66'(p1_ff >>> lif_pkg::FRACTION_BITS));
      num   = lif_pkg::sat32(66'(cfg.icur) - 66'(leak));
      p2_in = num * $signed({1'b0, cfg.invc});
      deriv = lif_pkg::sat32(66'(p2_ff >>> lif_pkg::FRACTION_BITS));
      p3_in = $signed({1'b0, cfg.h}) * deriv;
      k_in  = lif_pkg::sat32(66'(p3_ff >>> lif_pkg::FRACTION_BITS));
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < 4; i++) begin
            valid_ff[i] <= 1'b0;
         end
      end else if (en) begin
         valid_ff[0] <= in_valid;
         for (int i = 1; i < 4; i++) begin
            valid_ff[i] <= valid_ff[i-1];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         side_ff[0] <= side_in;
         for (int i = 1; i < 4; i++) begin
            side_ff[i] <= side_ff[i-1];
         end
         p1_ff <= p1_in;
         p2_ff <= p2_in;
         p3_ff <= p3_in;
         k_ff  <= k_in;
      end
   end

   always_comb begin
      hit = 1'b0;
      for (int i = 0; i < 4; i++) begin
         if (valid_ff[i] && side_ff[i].idx == probe_idx) begin
            hit = 1'b1;
         end
      end
   end

   assign out_valid = valid_ff[3];
   assign k_out     = k_ff;
   assign side_out  = side_ff[3];

endmodule

// ===== rtl/lif_neuron_rk4_update_core.sv =====
// top level: voltage store memory, four chained rk4 slope units, divide by six, write back
// depends on lif_pkg and lif_slope_unit
// result path: stage s1, the four slope units, divide stages a, b and c, then the output register
// throughput: one word per cycle while the output is not stalled and no word in flight addresses the same neuron;
// a word whose neuron is still in flight waits until that write back
// reset: synchronous; clears the pipeline and loads register defaults, store is not cleared
`timescale 1ns / 1ps

module lif_neuron_rk4_update_core (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         csr_wr_en,
   input  logic [2:0]                   csr_index,
   input  logic [31:0]                  csr_wdata,
   input  logic                         req_valid,
   output logic                         req_stall,
   input  logic                         req_func,
   input  logic [lif_pkg::IDX_W-1:0]    req_neuron_index,
   input  logic signed [31:0]           req_load_voltage,
   output logic                         rsp_valid,
   input  logic                         rsp_stall,
   output logic [lif_pkg::IDX_W-1:0]    rsp_out_index,
   output logic signed [31:0]           rsp_new_voltage,
   output logic                         rsp_spiked
);

   // configuration registers
   lif_pkg::cfg_type cfg_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.gl          <= lif_pkg::LEAK_RESET;
         cfg_ff.rest        <= lif_pkg::REST_RESET;
         cfg_ff.invc        <= lif_pkg::INVC_RESET;
         cfg_ff.icur        <= lif_pkg::ICUR_RESET;
         cfg_ff.h           <= lif_pkg::STEP_RESET;
         cfg_ff.reset_level <= lif_pkg::RLVL_RESET;
         cfg_ff.threshold   <= lif_pkg::THRES_RESET;
      end else if (csr_wr_en) begin
         unique case (lif_pkg::csr_index_type'(csr_index))
            lif_pkg::REG_LEAK:  cfg_ff.gl          <= csr_wdata[30:0];
            lif_pkg::REG_REST:  cfg_ff.rest        <= csr_wdata;
            lif_pkg::REG_INVC:  cfg_ff.invc        <= csr_wdata[30:0];
            lif_pkg::REG_ICUR:  cfg_ff.icur        <= csr_wdata;
            lif_pkg::REG_STEP:  cfg_ff.h           <= csr_wdata[30:0];
            lif_pkg::REG_RLVL:  cfg_ff.reset_level <= csr_wdata;
            lif_pkg::REG_THRES: cfg_ff.threshold   <= csr_wdata;
            default: ;
         endcase
      end
   end

   // whole pipeline moves unless a result sits in the output register and is stalled
   logic en;
   logic accept;
   logic hit;

   assign en     = !(rsp_valid && rsp_stall);
   assign accept = req_valid && !req_stall;

   // stage s1: word registered, store read in flight
   logic               s1_valid_ff;
   lif_pkg::side_type  s1_side_ff;
   lif_pkg::side_type  s1_side_in;
   logic signed [31:0] rd_ff;
   logic signed [31:0] voltage_mem [lif_pkg::NEURON_COUNT];

   always_comb begin
      s1_side_in.func     = lif_pkg::func_type'(req_func);
      s1_side_in.idx      = req_neuron_index;
      s1_side_in.in_range = {1'b0, req_neuron_index} < (lif_pkg::IDX_W+1)'(lif_pkg::NEURON_COUNT);
      s1_side_in.v        = req_load_voltage;
      s1_side_in.k1       = '0;
      s1_side_in.k2       = '0;
      s1_side_in.k3       = '0;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
      end else if (en) begin
         s1_valid_ff <= accept;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         s1_side_ff <= s1_side_in;
      end
   end

   // starting voltage: stored value for a step, load data otherwise
   lif_pkg::side_type u1_side;
   always_comb begin
      u1_side = s1_side_ff;
      if (s1_side_ff.func == lif_pkg::FUNC_STEP) begin
         u1_side.v = rd_ff;
      end
   end

   // four slope units; the next argument is formed from the previous slope
   logic               u_valid [4];
   logic signed [31:0] u_k     [4];
   lif_pkg::side_type  u_side  [4];
   logic               u_hit   [4];
   lif_pkg::side_type  u2_side, u3_side, u4_side;
   logic signed [31:0] x2, x3, x4;

   always_comb begin
      u2_side    = u_side[0];
      u2_side.k1 = u_k[0];
      x2         = lif_pkg::sat32(66'(u_side[0].v) + 66'(u_k[0] >>> 1));
      u3_side    = u_side[1];
      u3_side.k2 = u_k[1];
      x3         = lif_pkg::sat32(66'(u_side[1].v) + 66'(u_k[1] >>> 1));
      u4_side    = u_side[2];
      u4_side.k3 = u_k[2];
      x4         = lif_pkg::sat32(66'(u_side[2].v) + 66'(u_k[2]));
   end

   lif_slope_unit u_slope1 (
      .clock(clock), .reset(reset), .en(en), .cfg(cfg_ff),
      .in_valid(s1_valid_ff), .x_in(u1_side.v), .side_in(u1_side),
      .probe_idx(req_neuron_index),
      .out_valid(u_valid[0]), .k_out(u_k[0]), .side_out(u_side[0]), .hit(u_hit[0])
   );

   lif_slope_unit u_slope2 (
      .clock(clock), .reset(reset), .en(en), .cfg(cfg_ff),
      .in_valid(u_valid[0]), .x_in(x2), .side_in(u2_side),
      .probe_idx(req_neuron_index),
      .out_valid(u_valid[1]), .k_out(u_k[1]), .side_out(u_side[1]), .hit(u_hit[1])
   );

   lif_slope_unit u_slope3 (
      .clock(clock), .reset(reset), .en(en), .cfg(cfg_ff),
      .in_valid(u_valid[1]), .x_in(x3), .side_in(u3_side),
      .probe_idx(req_neuron_index),
      .out_valid(u_valid[2]), .k_out(u_k[2]), .side_out(u_side[2]), .hit(u_hit[2])
   );

   lif_slope_unit u_slope4 (
      .clock(clock), .reset(reset), .en(en), .cfg(cfg_ff),
      .in_valid(u_valid[2]), .x_in(x4), .side_in(u4_side),
      .probe_idx(req_neuron_index),
      .out_valid(u_valid[3]), .k_out(u_k[3]), .side_out(u_side[3]), .hit(u_hit[3])
   );

   // divide by six: floor(sum/6) = floor(floor(sum/2)/3), biased to stay non-negative,
   // then split into two 17-bit digits for the divide by three
   logic signed [35:0] sum;
   logic signed [35:0] biased;
   logic               a_valid_ff, b_valid_ff, c_valid_ff;
   lif_pkg::side_type  a_side_ff, b_side_ff, c_side_ff;
   logic [33:0]        a_u_ff;
   logic [16:0]        b_qa_ff;
   logic [18:0]        b_rest_ff;
   logic signed [33:0] c_incr_ff;
   logic [18:0]        qa_full, qb_full;
   logic [18:0]        ra;
   logic [18:0]        rest_in;
   logic [33:0]        qoff;
   logic signed [33:0] incr_in;

   always_comb begin
      sum     = 36'(u_side[3].k1) + (36'(u_side[3].k2) <<< 1)
              + (36'(u_side[3].k3) <<< 1) + 36'(u_k[3]);
      biased  = (sum >>> 1) + lif_pkg::DIV_OFFSET;
      qa_full = lif_pkg::div3({2'b00, a_u_ff[33:17]});
      ra      = {2'b00, a_u_ff[33:17]} - 19'(qa_full * 19'd3);
      rest_in = {ra[1:0], a_u_ff[16:0]};
      qb_full = lif_pkg::div3(b_rest_ff);
      qoff    = {b_qa_ff, 17'd0} + 34'(qb_full);
      incr_in = $signed(qoff) - lif_pkg::DIV_BIAS;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         a_valid_ff <= 1'b0;
         b_valid_ff <= 1'b0;
         c_valid_ff <= 1'b0;
      end else if (en) begin
         a_valid_ff <= u_valid[3];
         b_valid_ff <= a_valid_ff;
         c_valid_ff <= b_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         a_side_ff <= u_side[3];
         a_u_ff    <= biased[33:0];
         b_side_ff <= a_side_ff;
         b_qa_ff   <= qa_full[16:0];
         b_rest_ff <= rest_in;
         c_side_ff <= b_side_ff;
         c_incr_ff <= incr_in;
      end
   end

   // final: add increment, threshold compare, write back and output register
   logic signed [31:0] stepped;
   logic signed [31:0] result;
   logic               spike;
   logic               wr_en;

   always_comb begin
      stepped = lif_pkg::sat32(66'(c_side_ff.v) + 66'(c_incr_ff));
      result  = c_side_ff.v;
      spike   = 1'b0;
      if (!c_side_ff.in_range) begin
         result = '0;
      end else if (c_side_ff.func == lif_pkg::FUNC_STEP) begin
         if (stepped >= cfg_ff.threshold) begin
            result = cfg_ff.reset_level;
            spike  = 1'b1;
         end else begin
            result = stepped;
         end
      end
      wr_en = en && c_valid_ff && c_side_ff.in_range;
   end

   // store with one read and one write port: read for the incoming word, write for the retiring one
   always_ff @(posedge clock) begin
      if (en) begin
         rd_ff <= voltage_mem[req_neuron_index];
      end
      if (wr_en) begin
         voltage_mem[c_side_ff.idx] <= result;
      end
   end

   logic                       rsp_valid_ff;
   logic [lif_pkg::IDX_W-1:0]  rsp_idx_ff;
   logic signed [31:0]         rsp_voltage_ff;
   logic                       rsp_spiked_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (en) begin
         rsp_valid_ff <= c_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         rsp_idx_ff     <= c_side_ff.idx;
         rsp_voltage_ff <= result;
         rsp_spiked_ff  <= spike;
      end
   end

   // interlock: hold a word whose neuron is still between read and write back
   always_comb begin
      hit = (s1_valid_ff && s1_side_ff.idx == req_neuron_index)
         || u_hit[0] || u_hit[1] || u_hit[2] || u_hit[3]
         || (a_valid_ff && a_side_ff.idx == req_neuron_index)
         || (b_valid_ff && b_side_ff.idx == req_neuron_index)
         || (c_valid_ff && c_side_ff.idx == req_neuron_index);
   end

   assign req_stall       = !en || hit;
   assign rsp_valid       = rsp_valid_ff;
   assign rsp_out_index   = rsp_idx_ff;
   assign rsp_new_voltage = rsp_voltage_ff;
   assign rsp_spiked      = rsp_spiked_ff;

   // an accepted word shows up in the first stage
   assert property (@(posedge clock) disable iff (reset)
      accept |=> s1_valid_ff)
      else $error("accepted word lost at stage one");

   // a spike result always carries the reset level
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_spiked |-> rsp_new_voltage == cfg_ff.reset_level)
      else $error("spike without reset level");

   // a frozen pipeline keeps its last stage and the waiting result
   assert property (@(posedge clock) disable iff (reset)
      !en |=> $stable(c_valid_ff) && $stable(rsp_voltage_ff))
      else $error("pipeline moved while frozen");

   // no store write while the output is stalled
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |-> !wr_en)
      else $error("write back during output stall");

endmodule
